// ----- hdl/baro_pkg.sv -----
// Package for the barometer compensation block: register indexes, conversion codes,
// datapath widths and the microcode ROM of the sequencer.
// No dependencies.
package baro_pkg;

	localparam int RAW_W   = 24;
	localparam int COEF_W  = 16;
	localparam int DT_W    = 26;
	localparam int SENS_W  = 35;
	localparam int OFF_W   = 36;
	localparam int MUL_A_W = 35;
	localparam int MUL_B_W = 25;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int PC_W    = 4;
	localparam int IDX_W   = 3;

	localparam logic [15:0] TEMP_BASE = 16'd2000;

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_C1 = 3'd0;
	localparam logic [IDX_W-1:0] REG_C2 = 3'd1;
	localparam logic [IDX_W-1:0] REG_C3 = 3'd2;
	localparam logic [IDX_W-1:0] REG_C4 = 3'd3;
	localparam logic [IDX_W-1:0] REG_C5 = 3'd4;
	localparam logic [IDX_W-1:0] REG_C6 = 3'd5;

	// conversion request codes
	localparam logic [1:0] CONV_NONE        = 2'd0;
	localparam logic [1:0] CONV_PRESSURE    = 2'd1;
	localparam logic [1:0] CONV_TEMPERATURE = 2'd2;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_DT,
		OP_MUL,
		OP_TEMP,
		OP_OFF,
		OP_SENS,
		OP_PRES,
		OP_END
	} op_t;

	typedef enum logic {
		A_DT,
		A_SENS
	} a_sel_t;

	typedef enum logic [1:0] {
		B_C3,
		B_C4,
		B_C6,
		B_RAW
	} b_sel_t;

	typedef enum logic [1:0] {
		J_NONE,
		J_ALWAYS,
		J_PH2,
		J_ODD
	} jump_t;

	typedef struct packed {
		op_t             op;
		a_sel_t          a_sel;
		b_sel_t          b_sel;
		jump_t           jump;
		logic [PC_W-1:0] target;
	} ucode_t;

	localparam logic [PC_W-1:0] PC_PRESSURE = 4'd5;
	localparam logic [PC_W-1:0] PC_END      = 4'd11;

	// Program: dispatch on phase, temperature path, pressure path, common end step.
	function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
		ucode_t w;
		w = '{op: OP_END, a_sel: A_DT, b_sel: B_C3, jump: J_NONE, target: PC_END};
		case (pc)
			4'd0:  w = '{op: OP_NOP,  a_sel: A_DT,   b_sel: B_C3,  jump: J_PH2,
				target: PC_PRESSURE};
			4'd1:  w = '{op: OP_NOP,  a_sel: A_DT,   b_sel: B_C3,  jump: J_ODD,
				target: PC_END};
			4'd2:  w = '{op: OP_DT,   a_sel: A_DT,   b_sel: B_C3,  jump: J_NONE,
				target: PC_END};
			4'd3:  w = '{op: OP_MUL,  a_sel: A_DT,   b_sel: B_C6,  jump: J_NONE,
				target: PC_END};
			4'd4:  w = '{op: OP_TEMP, a_sel: A_DT,   b_sel: B_C3,  jump: J_ALWAYS,
				target: PC_END};
			4'd5:  w = '{op: OP_MUL,  a_sel: A_DT,   b_sel: B_C4,  jump: J_NONE,
				target: PC_END};
			4'd6:  w = '{op: OP_OFF,  a_sel: A_DT,   b_sel: B_C3,  jump: J_NONE,
				target: PC_END};
			4'd7:  w = '{op: OP_MUL,  a_sel: A_DT,   b_sel: B_C3,  jump: J_NONE,
				target: PC_END};
			4'd8:  w = '{op: OP_SENS, a_sel: A_DT,   b_sel: B_C3,  jump: J_NONE,
				target: PC_END};
			4'd9:  w = '{op: OP_MUL,  a_sel: A_SENS, b_sel: B_RAW, jump: J_NONE,
				target: PC_END};
			4'd10: w = '{op: OP_PRES, a_sel: A_DT,   b_sel: B_C3,  jump: J_NONE,
				target: PC_END};
			default: w = '{op: OP_END, a_sel: A_DT,  b_sel: B_C3,  jump: J_NONE,
				target: PC_END};
		endcase
		return w;
	endfunction

endpackage

// ----- hdl/baro_pressure_temp_compensation_top.sv -----
// Top level of the barometer pressure/temperature compensation block: config registers,
// microcoded sequencer, shared multiplier datapath and output register.
// Depends on baro_pkg.
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data      | in
//  in      | in_valid, in_ready, adc_raw                    | in
//  out     | out_valid, out_ready, pressure_half,           | out
//          | temperature_low, start_conversion              |
//
// One input beat runs the microprogram from step 0 to the end step: odd phases go
// from the dispatch straight to the end step, phase 0 runs the temperature path and
// phase 2 the pressure path; one 35x25 multiplier, shared over the steps, sets their length.
// in_ready is high whenever no program is running; the end step holds while the
// output register still holds an untaken beat. cfg_ready is always high.
// Reset clears coefficients, phase and held values.
module baro_pressure_temp_compensation_top
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [baro_pkg::IDX_W-1:0] cfg_index,
	input  logic [15:0]             cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [23:0]             adc_raw,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [15:0]             pressure_half,
	output logic [15:0]             temperature_low,
	output logic [1:0]              start_conversion
);
	import baro_pkg::*;

	logic [COEF_W-1:0] c1_q, c2_q, c3_q, c4_q, c5_q, c6_q;

	logic                    busy_q;
	logic [PC_W-1:0]         pc_q;
	logic [1:0]              phase_q;
	logic [RAW_W-1:0]        raw_q;
	logic signed [DT_W-1:0]  dt_q;
	logic signed [OFF_W-1:0] off_q;
	logic signed [SENS_W-1:0] sens_q;
	logic signed [PROD_W-1:0] prod_q;
	logic [15:0]             temp_q;
	logic [15:0]             pres_q;
	logic                    out_valid_q;
	logic [15:0]             pressure_half_q;
	logic [15:0]             temperature_low_q;
	logic [1:0]              start_conversion_q;

	ucode_t                  uw;
	logic                    taken;
	logic                    end_go;
	logic [PC_W-1:0]         pc_next;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  mul_p;
	logic signed [DT_W-1:0]    dt_next;
	logic signed [PROD_W-1:0]  sh23, sh7, sh8, sh21;
	logic [15:0]               temp_next;
	logic signed [OFF_W-1:0]   off_next;
	logic signed [SENS_W-1:0]  sens_next;
	logic signed [39:0]        p_diff;
	logic signed [39:0]        p_shift;
	logic [1:0]                conv;

	assign cfg_ready        = 1'b1;
	assign in_ready         = !busy_q;
	assign out_valid        = out_valid_q;
	assign pressure_half    = pressure_half_q;
	assign temperature_low  = temperature_low_q;
	assign start_conversion = start_conversion_q;

	assign uw = ucode_rom(pc_q);

	always_comb begin
		case (uw.jump)
			J_NONE:   taken = 1'b0;
			J_ALWAYS: taken = 1'b1;
			J_PH2:    taken = (phase_q == 2'd2);
			J_ODD:    taken = phase_q[0];
			default:  taken = 1'b0;
		endcase
		pc_next = taken ? uw.target : pc_q + 1'b1;
	end

	// end step completes only when the output slot is free or is being taken
	assign end_go = busy_q && (uw.op == OP_END) && (!out_valid_q || out_ready);

	always_comb begin
		case (uw.a_sel)
			A_DT:    mul_a = MUL_A_W'(dt_q);
			A_SENS:  mul_a = sens_q;
			default: mul_a = MUL_A_W'(dt_q);
		endcase
		case (uw.b_sel)
			B_C3:    mul_b = $signed({9'b0, c3_q});
			B_C4:    mul_b = $signed({9'b0, c4_q});
			B_C6:    mul_b = $signed({9'b0, c6_q});
			B_RAW:   mul_b = $signed({1'b0, raw_q});
			default: mul_b = $signed({9'b0, c3_q});
		endcase
	end

	assign mul_p = mul_a * mul_b;

	assign dt_next   = $signed({2'b0, raw_q}) - $signed({2'b0, c5_q, 8'b0});
	assign sh23      = prod_q >>> 23;
	assign sh7       = prod_q >>> 7;
	assign sh8       = prod_q >>> 8;
	assign sh21      = prod_q >>> 21;
	assign temp_next = sh23[15:0] + TEMP_BASE;
	assign off_next  = $signed({4'b0, c2_q, 16'b0}) + $signed(sh7[OFF_W-1:0]);
	assign sens_next = $signed({4'b0, c1_q, 15'b0}) + $signed(sh8[SENS_W-1:0]);
	assign p_diff    = $signed(sh21[39:0]) - 40'(off_q);
	assign p_shift   = p_diff >>> 15;

	always_comb begin
		case (phase_q)
			2'd0:    conv = CONV_PRESSURE;
			2'd2:    conv = CONV_TEMPERATURE;
			default: conv = CONV_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c1_q <= '0;
			c2_q <= '0;
			c3_q <= '0;
			c4_q <= '0;
			c5_q <= '0;
			c6_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_C1:  c1_q <= cfg_data;
				REG_C2:  c2_q <= cfg_data;
				REG_C3:  c3_q <= cfg_data;
				REG_C4:  c4_q <= cfg_data;
				REG_C5:  c5_q <= cfg_data;
				REG_C6:  c6_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pc_q        <= '0;
			phase_q     <= '0;
			dt_q        <= '0;
			temp_q      <= '0;
			pres_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			if (!busy_q) begin
				if (in_valid) begin
					busy_q <= 1'b1;
					pc_q   <= '0;
				end
			end else if (uw.op == OP_END) begin
				if (end_go) begin
					busy_q      <= 1'b0;
					pc_q        <= '0;
					phase_q     <= phase_q + 1'b1;
					out_valid_q <= 1'b1;
				end
			end else begin
				pc_q <= pc_next;
				case (uw.op)
					OP_DT:   dt_q   <= dt_next;
					OP_TEMP: temp_q <= temp_next;
					OP_PRES: pres_q <= p_shift[16:1];
					default: ;
				endcase
			end
		end
	end

	// datapath payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			raw_q <= adc_raw;
		if (busy_q) begin
			case (uw.op)
				OP_MUL:  prod_q <= mul_p;
				OP_OFF:  off_q  <= off_next;
				OP_SENS: sens_q <= sens_next;
				default: ;
			endcase
		end
		if (end_go) begin
			pressure_half_q    <= (phase_q == 2'd2) ? p_shift[16:1] : pres_q;
			temperature_low_q  <= temp_q;
			start_conversion_q <= conv;
		end
	end

endmodule

// ----- tb/baro_pressure_temp_compensation_top_tb.sv -----
// Testbench for baro_pressure_temp_compensation_top: drives polling ticks and calibration
// writes, predicts each tick report from its own model of the compensation math, checks it.
// Depends on baro_pkg and the top level.
`timescale 1ns / 1ps

module baro_pressure_temp_compensation_top_tb;
	import baro_pkg::*;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int SETTLE_CYCLES = 16;
	localparam logic [1:0] PH_TEMP  = 2'd0;
	localparam logic [1:0] PH_PRES  = 2'd2;
	localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam logic [23:0] RAW_MAX = 24'hFF_FFFF;

	typedef struct packed {
		logic [15:0] pressure_half;
		logic [15:0] temperature_low;
		logic [1:0]  start_conversion;
	} tick_report_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [IDX_W-1:0]  cfg_index = '0;
	logic [15:0]       cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [23:0]       adc_raw = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [15:0]       pressure_half;
	logic [15:0]       temperature_low;
	logic [1:0]        start_conversion;

	// model state
	logic [15:0]        cal_coef [6] = '{default: 16'd0};
	logic [1:0]         tick_phase = '0;
	logic signed [25:0] temp_diff = '0;
	logic [31:0]        temp_held = '0;
	logic [31:0]        pres_held = '0;

	tick_report_t report_q [$];
	int           fail_cnt = 0;
	int           cycle_cnt = 0;
	int           send_idle_pct = 0;
	int           recv_stall_pct = 0;

	baro_pressure_temp_compensation_top i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.adc_raw          (adc_raw),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.pressure_half    (pressure_half),
		.temperature_low  (temperature_low),
		.start_conversion (start_conversion)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("FAIL baro_pressure_temp_compensation_top");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// One tick of first-order compensation; advances the model state.
	function automatic tick_report_t compensate_tick(input logic [23:0] raw);
		tick_report_t r;
		longint raw_l;
		longint dt;
		longint t;
		longint off;
		longint sens;
		longint p;
		raw_l = longint'(raw);
		r.start_conversion = CONV_NONE;
		if (tick_phase == PH_TEMP) begin
			dt = raw_l - longint'(cal_coef[REG_C5]) * 256;
			t = ((dt * longint'(cal_coef[REG_C6])) >>> 23) + longint'(TEMP_BASE);
			temp_diff = dt[25:0];
			temp_held = t[31:0];
			r.start_conversion = CONV_PRESSURE;
		end else if (tick_phase == PH_PRES) begin
			dt = longint'(temp_diff);
			off = longint'(cal_coef[REG_C2]) * 65536 +
				((longint'(cal_coef[REG_C4]) * dt) >>> 7);
			sens = longint'(cal_coef[REG_C1]) * 32768 +
				((longint'(cal_coef[REG_C3]) * dt) >>> 8);
			p = (((raw_l * sens) >>> 21) - off) >>> 15;
			pres_held = p[31:0];
			r.start_conversion = CONV_TEMPERATURE;
		end
		r.pressure_half = pres_held[16:1];
		r.temperature_low = temp_held[15:0];
		tick_phase = tick_phase + 2'd1;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$error("%s expected %h actual %h", name, want, got);
			fail_cnt++;
		end
	endtask

	// Track accepted beats on all three channels.
	always @(posedge clk) begin : monitor
		tick_report_t want;
		if (in_valid && in_ready)
			report_q.push_back(compensate_tick(adc_raw));
		if (cfg_valid && cfg_ready && cfg_index <= REG_C6)
			cal_coef[cfg_index] = cfg_data;
		if (out_valid && out_ready) begin
			if (report_q.size() == 0) begin
				$error("report beat with nothing pending");
				fail_cnt++;
			end else begin
				want = report_q.pop_front();
				check_field("pressure_half", want.pressure_half, pressure_half);
				check_field("temperature_low", want.temperature_low, temperature_low);
				check_field("start_conversion", 16'(want.start_conversion),
					16'(start_conversion));
			end
		end
	end

	// Leaves in_valid high so back-to-back ticks need no lowering.
	task automatic send_tick(input logic [23:0] raw);
		int gap;
		gap = 0;
		while (gap < 30 && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		adc_raw <= raw;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Drop valid, drain every pending report, then let the sequencer settle.
	task automatic wait_idle();
		in_valid <= 1'b0;
		cfg_valid <= 1'b0;
		@(posedge clk);
		while (report_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_coeffs(input logic [15:0] c1, input logic [15:0] c2,
			input logic [15:0] c3, input logic [15:0] c4, input logic [15:0] c5,
			input logic [15:0] c6);
		wait_idle();
		cfg_write(REG_C1, c1);
		cfg_write(REG_C2, c2);
		cfg_write(REG_C3, c3);
		cfg_write(REG_C4, c4);
		cfg_write(REG_C5, c5);
		cfg_write(REG_C6, c6);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [15:0] rand_coef();
		case ($urandom_range(7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [23:0] rand_raw();
		int near_ref;
		case ($urandom_range(9))
			0: return 24'h00_0000;
			1: return RAW_MAX;
			2, 3: begin
				// land close to the reference so dT hovers around zero
				near_ref = int'(cal_coef[REG_C5]) * 256 + int'($urandom_range(8191)) - 4096;
				if (near_ref < 0)
					near_ref = 0;
				if (near_ref > int'(RAW_MAX))
					near_ref = int'(RAW_MAX);
				return 24'(near_ref);
			end
			default: return 24'($urandom);
		endcase
	endfunction

	// Coefficients at reset are zero; the formulas still apply.
	task automatic test_uncalibrated();
		send_tick(24'h00_0000);
		send_tick(RAW_MAX);
		send_tick(RAW_MAX);
		send_tick(24'h55_AAAA);
	endtask

	task automatic test_typical_calibration();
		program_coeffs(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312);
		send_tick(24'd8569150);
		send_tick(24'd1234);
		send_tick(24'd9085466);
		send_tick(24'd4321);
		send_tick(24'd8077636);
		send_tick(24'd0);
		send_tick(24'd6465444);
		send_tick(24'hAA_5555);
	endtask

	// All coefficients at maximum, readings at both ends: dT at its most negative
	// and most positive, the ignored phases carry extreme readings as well.
	task automatic test_extreme_calibration();
		program_coeffs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_tick(24'h00_0000);
		send_tick(RAW_MAX);
		send_tick(RAW_MAX);
		send_tick(RAW_MAX);
		send_tick(RAW_MAX);
		send_tick(24'h00_0000);
		send_tick(24'h00_0000);
		send_tick(RAW_MAX);
	endtask

	// Writes to the spare indexes must not touch any coefficient.
	task automatic test_unused_register();
		wait_idle();
		cfg_write(REG_SPARE_LO, 16'($urandom));
		cfg_write(REG_SPARE_HI, 16'($urandom));
		cfg_valid <= 1'b0;
		send_tick(24'($urandom));
		send_tick(24'($urandom));
		send_tick(24'($urandom));
		send_tick(24'($urandom));
	endtask

	task automatic test_random_ticks(input int idle_pct, input int stall_pct,
			input int n_chunks, input int chunk_len);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (int c = 0; c < n_chunks; c++) begin
			program_coeffs(rand_coef(), rand_coef(), rand_coef(), rand_coef(),
				rand_coef(), rand_coef());
			for (int i = 0; i < chunk_len; i++)
				send_tick(rand_raw());
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 20;
		recv_stall_pct = 20;
		test_uncalibrated();
		test_typical_calibration();
		test_extreme_calibration();
		test_unused_register();
		test_random_ticks(38, 65, 5, 82);
		test_random_ticks(65, 38, 5, 82);
		test_random_ticks(0, 0, 5, 82);
		wait_idle();
		if (fail_cnt == 0)
			$display("PASS baro_pressure_temp_compensation_top");
		else
			$display("FAIL baro_pressure_temp_compensation_top");
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/baro_pkg.sv
hdl/baro_pressure_temp_compensation_top.sv
tb/baro_pressure_temp_compensation_top_tb.sv
